FILE: rtl/mrte_pkg.sv
package mrte_pkg;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] via;
        logic [7:0]  hops;
        logic [7:0]  qual;
        logic [31:0] seen;
    } entry_t;

    // per-cycle shift control shared by every cell of the ring
    typedef struct packed {
        logic rotate;  // whole ring moves one place toward the head
        logic drop;    // only the cells in front of the drop point move
    } cell_ctl_t;

    typedef enum logic [1:0] {
        OP_PACKET  = 2'd0,
        OP_ADD     = 2'd1,
        OP_FIND    = 2'd2,
        OP_CLEANUP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_ROUTE = 2'd2,
        ST_FULL     = 2'd3
    } route_status_t;

    localparam logic [1:0] REG_OWN_ID   = 2'd0;
    localparam logic [1:0] REG_BCAST_ID = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [15:0] OWN_ID_RST   = 16'd1;
    localparam logic [15:0] BCAST_ID_RST = 16'hFFFF;
    localparam logic [31:0] TIMEOUT_RST  = 32'd300000;

endpackage

FILE: rtl/mrte_if.sv
interface mrte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] target_node;
    logic [15:0] next_hop_node;
    logic [7:0]  hop_count_in;
    logic [7:0]  link_quality;
    logic [31:0] current_time_ms;

    modport source (output valid, opcode, target_node, next_hop_node, hop_count_in,
                    link_quality, current_time_ms, input ready);
    modport sink   (input valid, opcode, target_node, next_hop_node, hop_count_in,
                    link_quality, current_time_ms, output ready);
endinterface

interface mrte_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] route_via;
    logic [7:0]  route_hops;
    logic [4:0]  entry_count;

    modport source (output valid, status, route_via, route_hops, entry_count, input ready);
    modport sink   (input valid, status, route_via, route_hops, entry_count, output ready);
endinterface

interface mrte_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mrte_cell.sv
module mrte_cell
    import mrte_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      in_front,
    input  entry_t    nbr,
    output entry_t    ent
);

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rotate || (ctl.drop && in_front))
        begin
            entry_reg <= nbr;
        end
    end

    assign ent = entry_reg;

endmodule

FILE: rtl/mesh_route_table_engine_unit.sv
// Distance-vector route table held in a ring of MAX_ENTRIES cells. Every
// operation rotates the ring once past the head cell in S_SCAN, then S_FIN writes
// the result to the output register once it is free; cleanup first passes through
// S_ALIGN, rotating once per expired route to realign the ring. One
// operation is in flight at a time; a result waits in the output register and a
// new request is taken meanwhile.
// Configuration writes are accepted every cycle and should be issued while idle.
module mesh_route_table_engine_unit
    import mrte_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mrte_req_if.sink   req,
    mrte_rsp_if.source rsp,
    mrte_cfg_if.sink   cfg
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ALIGN,
        S_FIN
    } state_t;

    state_t      state_reg;
    logic [15:0] own_reg, bcast_reg;
    logic [31:0] timeout_reg;

    opcode_t     op_reg;
    logic [15:0] target_reg, hop_node_reg;
    logic [7:0]  hops_reg, qual_reg;
    logic [31:0] now_reg;

    logic [CW-1:0] count_reg, step_reg, drop_reg;
    logic          blended_reg, found_reg, inserted_reg;
    logic [15:0]   fvia_reg;
    logic [7:0]    fhops_reg;

    logic          rsp_valid_reg;
    route_status_t status_reg;
    logic [15:0]   via_out_reg;
    logic [7:0]    hops_out_reg;
    logic [CW-1:0] count_out_reg;

    entry_t    cells [MAX_ENTRIES];
    entry_t    head, tail;
    cell_ctl_t ctl;
    logic      head_valid, alive, add_en, blend_hit, dest_hit, better;
    logic [7:0] q_new;
    logic [9:0] blend_sum;
    logic       rsp_free;
    route_status_t status_next;

    assign head       = cells[0];
    assign head_valid = step_reg < count_reg;
    assign alive      = (now_reg - head.seen) < timeout_reg;
    assign q_new      = (op_reg == OP_PACKET) ? (8'd255 - hops_reg) : qual_reg;
    assign add_en     = ((op_reg == OP_PACKET) || (op_reg == OP_ADD)) && (target_reg != own_reg);
    assign blend_sum  = 10'(head.qual) * 10'd3 + 10'(q_new);
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    // head entry as it re-enters the ring at the tail
    always_comb
    begin
        tail      = head;
        blend_hit = (op_reg == OP_PACKET) && head_valid && !blended_reg
                    && (head.via == hop_node_reg);
        if (blend_hit)
        begin
            tail.qual = blend_sum[9:2];
        end
        dest_hit = add_en && head_valid && !found_reg && (head.dest == target_reg);
        better   = (hops_reg < tail.hops) || (q_new > tail.qual);
        if ((dest_hit && better)
            || (add_en && !found_reg && !inserted_reg && (step_reg == count_reg)))
        begin
            tail.dest = target_reg;
            tail.via  = hop_node_reg;
            tail.hops = hops_reg;
            tail.qual = q_new;
            tail.seen = now_reg;
        end
    end

    always_comb
    begin
        ctl.rotate = 1'b0;
        ctl.drop   = 1'b0;
        if (state_reg == S_SCAN)
        begin
            if ((op_reg == OP_CLEANUP) && head_valid && !alive)
            begin
                ctl.drop = 1'b1;
            end
            else
            begin
                ctl.rotate = 1'b1;
            end
        end
        else if (state_reg == S_ALIGN)
        begin
            ctl.rotate = 1'b1;
        end
    end

    for (genvar j = 0; j < MAX_ENTRIES; j++)
    begin : g_cell
        entry_t nbr;
        logic   front;
        if (j == MAX_ENTRIES - 1)
        begin : g_tail
            assign nbr = tail;
        end
        else
        begin : g_mid
            assign nbr = cells[j+1];
        end
        assign front = ((CW+1)'(j) + {1'b0, step_reg}) < (CW+1)'(MAX_ENTRIES);
        mrte_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .in_front (front),
            .nbr      (nbr),
            .ent      (cells[j])
        );
    end

    always_comb
    begin
        status_next = ST_OK;
        case (op_reg)
            OP_ADD:
            begin
                if (target_reg == own_reg)
                    status_next = ST_INVALID;
                else if (!found_reg && !inserted_reg)
                    status_next = ST_FULL;
            end
            OP_FIND:
            begin
                if ((target_reg != bcast_reg) && !found_reg)
                    status_next = ST_NO_ROUTE;
            end
            default: status_next = ST_OK;
        endcase
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= OWN_ID_RST;
            bcast_reg <= BCAST_ID_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OWN_ID:   own_reg     <= cfg.data[15:0];
                REG_BCAST_ID: bcast_reg   <= cfg.data[15:0];
                REG_TIMEOUT:  timeout_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            drop_reg      <= '0;
            blended_reg   <= 1'b0;
            found_reg     <= 1'b0;
            inserted_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_FIN))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg       <= opcode_t'(req.opcode);
                        target_reg   <= req.target_node;
                        hop_node_reg <= req.next_hop_node;
                        hops_reg     <= req.hop_count_in;
                        qual_reg     <= req.link_quality;
                        now_reg      <= req.current_time_ms;
                        step_reg     <= '0;
                        drop_reg     <= '0;
                        blended_reg  <= 1'b0;
                        found_reg    <= 1'b0;
                        inserted_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (blend_hit)
                        blended_reg <= 1'b1;
                    if (dest_hit)
                        found_reg <= 1'b1;
                    if (add_en && !found_reg && !inserted_reg && (step_reg == count_reg))
                        inserted_reg <= 1'b1;
                    if ((op_reg == OP_FIND) && head_valid && !found_reg
                        && (head.dest == target_reg) && alive)
                    begin
                        found_reg <= 1'b1;
                        fvia_reg  <= head.via;
                        fhops_reg <= head.hops;
                    end
                    if (ctl.drop)
                        drop_reg <= drop_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg <= '0;
                        if ((op_reg == OP_CLEANUP) && ((drop_reg != '0) || ctl.drop))
                            state_reg <= S_ALIGN;
                        else
                            state_reg <= S_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_ALIGN:
                begin
                    if (step_reg == drop_reg - 1'b1)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        via_out_reg   <= '0;
                        hops_out_reg  <= '0;
                        if (op_reg == OP_FIND)
                        begin
                            if (target_reg == bcast_reg)
                            begin
                                via_out_reg <= bcast_reg;
                            end
                            else if (found_reg)
                            begin
                                via_out_reg  <= fvia_reg;
                                hops_out_reg <= fhops_reg;
                            end
                        end
                        if (op_reg == OP_CLEANUP)
                        begin
                            count_reg     <= count_reg - drop_reg;
                            count_out_reg <= count_reg - drop_reg;
                        end
                        else if (inserted_reg)
                        begin
                            count_reg     <= count_reg + 1'b1;
                            count_out_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            count_out_reg <= count_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.route_via   = via_out_reg;
    assign rsp.route_hops  = hops_out_reg;
    assign rsp.entry_count = 5'(count_out_reg);

endmodule

FILE: rtl/mrte_checker.sv
module mrte_checker
    import mrte_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [15:0] rsp_via,
    input logic [7:0]  rsp_hops,
    input logic [4:0]  rsp_count
);

    localparam logic [6:0] MAX_CNT = 7'(MAX_ENTRIES);

    // a pending result must hold until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("result changed while stalled");

    // the engine goes busy right after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_via == 16'd0) && (rsp_hops == 8'd0))
        else $error("route fields set on failed lookup");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (MAX_ENTRIES < 32) |-> {2'b00, rsp_count} <= MAX_CNT)
        else $error("entry count above table size");

endmodule

bind mesh_route_table_engine_unit mrte_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_mrte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_via    (rsp.route_via),
    .rsp_hops   (rsp.route_hops),
    .rsp_count  (rsp.entry_count)
);
